// File: hdl/lid_keepalive_sleep_guard_assert.svh
// assertion macros for the lid keepalive sleep guard
`ifndef LID_KEEPALIVE_SLEEP_GUARD_ASSERT_SVH
`define LID_KEEPALIVE_SLEEP_GUARD_ASSERT_SVH
`ifndef SYNTHESIS
`define LKSG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lksg same-cycle check failed");
`define LKSG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lksg next-cycle check failed");
`else
`define LKSG_ASSERT_IMP(label, ante, cons)
`define LKSG_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hdl/lksg_pkg.sv
// shared types and constants for the lid keepalive sleep guard
package lksg_pkg;

    localparam int TIME_W      = 48;
    localparam int CNT_W       = 32;
    localparam int MIN_W       = 16;
    localparam int POLL_W      = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 72;

    localparam logic [POLL_W-1:0] POLL_PERIOD   = 5'd30;
    localparam logic [MIN_W-1:0]  MS_PER_MINUTE = 16'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEEPALIVE_MINUTES = 1'b0,
        CFG_LID_SERVICE_OK    = 1'b1
    } cfg_index_t;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              lid_read_ok;
        logic              lid_open;
        logic              connected;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] last_shut_frames;
        logic [CNT_W-1:0] last_shut_ms;
        logic             lid_is_shut;
        logic             sleep_changed;
        logic             sleep_allowed;
        logic             hold_active;
    } result_t;

    localparam int IN_ITEM_W = $bits(in_item_t);
    localparam int RESULT_W  = $bits(result_t);

endpackage

// File: hdl/lksg_in_reg.sv
// input register stage holding one accepted tick beat
module lksg_in_reg
    import lksg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  advance,
    output logic                  item_valid,
    output in_item_t              item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hdl/lksg_core.sv
// configuration registers, guard state and per-tick decision logic
module lksg_core
    import lksg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  advance,
    input  in_item_t              item,
    output result_t               result
);

    logic [MIN_W-1:0]  keepalive_minutes_reg;
    logic              lid_service_ok_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  limit_next;

    logic              sleep_blocked_reg, sleep_blocked_next;
    logic              lid_shut_reg, lid_shut_next;
    logic              shut_timing_reg, shut_timing_next;
    logic [TIME_W-1:0] shut_start_reg, shut_start_next;
    logic [CNT_W-1:0]  frame_count_reg, frame_count_next;
    logic [CNT_W-1:0]  last_frames_reg, last_frames_next;
    logic [CNT_W-1:0]  last_ms_reg, last_ms_next;
    logic [POLL_W-1:0] poll_cnt_reg, poll_cnt_next;

    logic              hold;
    logic              poll;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] elapsed;
    logic [CNT_W-1:0]  frame_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keepalive_minutes_reg <= '0;
            lid_service_ok_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_KEEPALIVE_MINUTES: keepalive_minutes_reg <= cfg_wdata[MIN_W-1:0];
                CFG_LID_SERVICE_OK:    lid_service_ok_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // hold length in ms from the minutes register, registered in limit_reg
    assign limit_next = CNT_W'({16'b0, keepalive_minutes_reg} * {16'b0, MS_PER_MINUTE});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else begin
            limit_reg <= limit_next;
        end
    end

    assign start_eff  = shut_timing_reg ? shut_start_reg : item.now_ms;
    assign elapsed    = item.now_ms - start_eff;
    assign frame_base = shut_timing_reg ? frame_count_reg : '0;
    assign poll       = (poll_cnt_reg <= 5'd1);

    always_comb begin
        sleep_blocked_next = sleep_blocked_reg;
        lid_shut_next      = lid_shut_reg;
        shut_timing_next   = shut_timing_reg;
        shut_start_next    = shut_start_reg;
        frame_count_next   = frame_count_reg;
        last_frames_next   = last_frames_reg;
        last_ms_next       = last_ms_reg;
        poll_cnt_next      = poll_cnt_reg;
        hold               = 1'b0;
        if (keepalive_minutes_reg == '0 || !item.connected) begin
            sleep_blocked_next = 1'b0;
            lid_shut_next      = 1'b0;
            shut_timing_next   = 1'b0;
        end else begin
            sleep_blocked_next = 1'b1;
            if (lid_service_ok_reg) begin
                if (poll) begin
                    poll_cnt_next = POLL_PERIOD;
                    if (item.lid_read_ok) begin
                        lid_shut_next = !item.lid_open;
                    end
                end else begin
                    poll_cnt_next = poll_cnt_reg - 5'd1;
                end
                if (!lid_shut_next) begin
                    if (shut_timing_reg) begin
                        last_ms_next     = elapsed[CNT_W-1:0];
                        last_frames_next = frame_count_reg;
                    end
                    shut_timing_next = 1'b0;
                    frame_count_next = '0;
                end else begin
                    shut_timing_next = 1'b1;
                    shut_start_next  = start_eff;
                    frame_count_next = frame_base + 32'd1;
                    if (elapsed >= {16'b0, limit_reg}) begin
                        sleep_blocked_next = 1'b0;
                    end
                    hold = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sleep_blocked_reg <= 1'b0;
            lid_shut_reg      <= 1'b0;
            shut_timing_reg   <= 1'b0;
            shut_start_reg    <= '0;
            frame_count_reg   <= '0;
            last_frames_reg   <= '0;
            last_ms_reg       <= '0;
            poll_cnt_reg      <= '0;
        end else if (advance) begin
            sleep_blocked_reg <= sleep_blocked_next;
            lid_shut_reg      <= lid_shut_next;
            shut_timing_reg   <= shut_timing_next;
            shut_start_reg    <= shut_start_next;
            frame_count_reg   <= frame_count_next;
            last_frames_reg   <= last_frames_next;
            last_ms_reg       <= last_ms_next;
            poll_cnt_reg      <= poll_cnt_next;
        end
    end

    always_comb begin
        result.hold_active      = hold;
        result.sleep_allowed    = !sleep_blocked_next;
        result.sleep_changed    = sleep_blocked_next != sleep_blocked_reg;
        result.lid_is_shut      = lid_shut_next;
        result.last_shut_ms     = last_ms_next;
        result.last_shut_frames = last_frames_next;
    end

endmodule

// File: hdl/lksg_out_reg.sv
// result register driving the master-side beat
module lksg_out_reg
    import lksg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  result_t                result,
    output logic                   load_ready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign load_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, result_reg};

endmodule

// File: hdl/lid_keepalive_sleep_guard.sv
// Lid keepalive sleep guard top level. One tick beat enters per clock cycle
// unless both registers are full and the output is stalled; its result beat
// is registered (input register, decision logic, result register). Throughput
// is one beat per cycle while the output is not stalled; the path between the
// registers is the 48-bit elapsed-time subtract and compare against the registered
// hold limit. A keepalive_minutes write reaches the limit register through the
// minutes register, so an item accepted on the following edge sees it.
`include "lid_keepalive_sleep_guard_assert.svh"
module lid_keepalive_sleep_guard
    import lksg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,  // 0 keepalive_minutes, 1 lid_service_ok
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // connected, lid_open, lid_read_ok, now_ms[47:0], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hold_active, sleep_allowed, sleep_changed, lid_is_shut,
    // last_shut_ms[31:0], last_shut_frames[31:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic     item_valid;
    in_item_t item;
    logic     out_ready;
    logic     advance;
    result_t  result;

    assign advance = item_valid && out_ready;

    lksg_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lksg_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    lksg_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result     (result),
        .load_ready (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // input side stalls only when both stages are full and the output is stalled
    `LKSG_ASSERT_IMP(a_stall_only_when_full, !s_tready, item_valid && m_tvalid && !m_tready)
    // a disconnected tick always releases sleep and drops the hold
    `LKSG_ASSERT_NXT(a_disconnect_allows_sleep, advance && !item.connected, m_tvalid && m_tdata[1] && !m_tdata[0])
    // a tracked hold implies a shut lid
    `LKSG_ASSERT_IMP(a_hold_implies_shut, m_tvalid && m_tdata[0], m_tdata[3])

endmodule

// File: verif/tb_lid_keepalive_sleep_guard.sv
// testbench for the lid keepalive sleep guard: directed and random tick beats checked against a predictor
module tb_lid_keepalive_sleep_guard;
    import lksg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 64;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 156;

    class guard_tracker;
        logic [MIN_W-1:0]  minutes;
        bit                service;
        bit                blocked;
        bit                lid_shut;
        bit                timing;
        logic [TIME_W-1:0] start_ms;
        logic [CNT_W-1:0]  frames;
        logic [CNT_W-1:0]  last_frames;
        logic [CNT_W-1:0]  last_ms;
        logic [POLL_W-1:0] countdown;
        result_t           decisions_due[$];
        int                errors;

        function new();
            minutes     = '0;
            service     = 1'b0;
            blocked     = 1'b0;
            lid_shut    = 1'b0;
            timing      = 1'b0;
            start_ms    = '0;
            frames      = '0;
            last_frames = '0;
            last_ms     = '0;
            countdown   = '0;
            errors      = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_KEEPALIVE_MINUTES: minutes = val[MIN_W-1:0];
                CFG_LID_SERVICE_OK:    service = val[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return decisions_due.size();
        endfunction

        function void note_tick(in_item_t t);
            bit                was_blocked;
            bit                hold;
            logic [TIME_W-1:0] elapsed;
            logic [63:0]       limit;
            result_t           r;
            was_blocked = blocked;
            hold        = 1'b0;
            limit       = 64'(minutes) * 64'(MS_PER_MINUTE);
            if (minutes == '0 || !t.connected) begin
                blocked  = 1'b0;
                lid_shut = 1'b0;
                timing   = 1'b0;
            end else begin
                blocked = 1'b1;
                if (service) begin
                    if (countdown <= 1) begin
                        countdown = POLL_PERIOD;
                        if (t.lid_read_ok)
                            lid_shut = !t.lid_open;
                    end else begin
                        countdown = countdown - 1'b1;
                    end
                    if (!lid_shut) begin
                        if (timing) begin
                            elapsed     = t.now_ms - start_ms;
                            last_ms     = elapsed[CNT_W-1:0];
                            last_frames = frames;
                        end
                        timing = 1'b0;
                        frames = '0;
                    end else begin
                        if (!timing) begin
                            timing   = 1'b1;
                            start_ms = t.now_ms;
                            frames   = '0;
                        end
                        frames  = frames + 1'b1;
                        elapsed = t.now_ms - start_ms;
                        if (64'(elapsed) >= limit)
                            blocked = 1'b0;
                        hold = 1'b1;
                    end
                end
            end
            r.hold_active      = hold;
            r.sleep_allowed    = !blocked;
            r.sleep_changed    = (blocked != was_blocked);
            r.lid_is_shut      = lid_shut;
            r.last_shut_ms     = last_ms;
            r.last_shut_frames = last_frames;
            decisions_due.push_back(r);
        endfunction

        function void flag(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            errors++;
            $display("%0t %s expected %0h actual %0h", $time, field, want, got);
        endfunction

        function void check_decision(result_t got);
            result_t want;
            if (decisions_due.size() == 0) begin
                errors++;
                $display("%0t unexpected result beat expected none actual %h", $time, got);
                return;
            end
            want = decisions_due.pop_front();
            if (got.hold_active !== want.hold_active)
                flag("hold_active", want.hold_active, got.hold_active);
            if (got.sleep_allowed !== want.sleep_allowed)
                flag("sleep_allowed", want.sleep_allowed, got.sleep_allowed);
            if (got.sleep_changed !== want.sleep_changed)
                flag("sleep_changed", want.sleep_changed, got.sleep_changed);
            if (got.lid_is_shut !== want.lid_is_shut)
                flag("lid_is_shut", want.lid_is_shut, got.lid_is_shut);
            if (got.last_shut_ms !== want.last_shut_ms)
                flag("last_shut_ms", want.last_shut_ms, got.last_shut_ms);
            if (got.last_shut_frames !== want.last_shut_frames)
                flag("last_shut_frames", want.last_shut_frames, got.last_shut_frames);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    guard_tracker      tracker = new();
    int                cycle_count = 0;
    bit                calm = 1'b0;
    bit                stall_req = 1'b0;
    logic [TIME_W-1:0] ms_now = '0;
    bit                want_shut = 1'b0;

    lid_keepalive_sleep_guard uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[lid_keepalive_sleep_guard] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_decision(result_t'(m_tdata[RESULT_W-1:0]));
    end

    initial begin
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (stall_req) begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                stall_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    function automatic in_item_t mk_tick(bit conn, bit open, bit ok, logic [TIME_W-1:0] now);
        in_item_t t;
        t.connected   = conn;
        t.lid_open    = open;
        t.lid_read_ok = ok;
        t.now_ms      = now;
        return t;
    endfunction

    function automatic in_item_t next_tick(logic [MIN_W-1:0] mins);
        in_item_t    t;
        logic [63:0] span;
        span = 64'(mins) * 64'(MS_PER_MINUTE) / 12;
        if (span < 4000)
            span = 4000;
        ms_now += TIME_W'($urandom_range(0, 32'(span)));
        if ($urandom_range(0, 99) == 0)
            ms_now = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 32'(span) * 8));
        if ($urandom_range(0, 44) == 0)
            want_shut = !want_shut;
        if ($urandom_range(0, 9) == 0) begin
            t = mk_tick(1'($urandom), 1'($urandom), 1'($urandom),
                        TIME_W'({$urandom, $urandom}));
        end else begin
            t = mk_tick($urandom_range(0, 49) != 0, !want_shut,
                        $urandom_range(0, 9) != 0, ms_now);
        end
        return t;
    endfunction

    task automatic send_tick(in_item_t t);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - IN_ITEM_W){1'b0}}, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_tick(t);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tracker.set_reg(idx, val);
        @(posedge aclk);
    endtask

    initial begin
        logic [MIN_W-1:0] phase_mins [N_PHASES];
        bit               phase_svc  [N_PHASES];
        phase_mins = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd1, 16'd5, 16'd1, 16'd3};
        phase_svc  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
        phase_mins[5] = MIN_W'($urandom_range(4, 65534));

        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_KEEPALIVE_MINUTES;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // hold disabled under reset settings
        send_tick(mk_tick(1'b1, 1'b1, 1'b1, {TIME_W{1'b1}}));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, '0));
        drain();
        write_reg(CFG_KEEPALIVE_MINUTES, 16'd1);
        write_reg(CFG_LID_SERVICE_OK, 16'd1);
        // shut across the time wrap, released exactly at the limit
        send_tick(mk_tick(1'b1, 1'b0, 1'b1, {TIME_W{1'b1}} - 48'd999));
        send_tick(mk_tick(1'b1, 1'b1, 1'b1, 48'd59000));
        send_tick(mk_tick(1'b1, 1'b0, 1'b0, 48'd59001));
        send_tick(mk_tick(1'b0, 1'b1, 1'b1, {TIME_W{1'b1}}));
        send_tick(mk_tick(1'b1, 1'b0, 1'b1, '0));
        send_tick(mk_tick(1'b1, 1'b1, 1'b0, 48'h5555_5555_5555));
        drain();
        write_reg(CFG_LID_SERVICE_OK, 16'd0);
        send_tick(mk_tick(1'b1, 1'b0, 1'b1, 48'd100));
        send_tick(mk_tick(1'b1, 1'b1, 1'b0, 48'hAAAA_AAAA_AAAA));
        send_tick(mk_tick(1'b0, 1'b0, 1'b1, 48'd200));
        drain();
        write_reg(CFG_KEEPALIVE_MINUTES, 16'd65535);
        write_reg(CFG_LID_SERVICE_OK, 16'd1);
        send_tick(mk_tick(1'b1, 1'b0, 1'b1, 48'd0));
        send_tick(mk_tick(1'b1, 1'b0, 1'b1, 48'd3_932_099_999));
        send_tick(mk_tick(1'b1, 1'b0, 1'b1, 48'd3_932_100_000));
        send_tick(mk_tick(1'b1, 1'b1, 1'b1, 48'hFFFF_0000_0000));

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_reg(CFG_KEEPALIVE_MINUTES, CFG_DATA_W'(phase_mins[p]));
            write_reg(CFG_LID_SERVICE_OK, CFG_DATA_W'(phase_svc[p]));
            calm = (p == N_PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 1 && i == 40)
                    stall_req = 1'b1;
                if (p == 2 && i == 80)
                    drain();
                send_tick(next_tick(phase_mins[p]));
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("[lid_keepalive_sleep_guard] OK");
        end else begin
            $display("[lid_keepalive_sleep_guard] ERROR");
        end
        $finish;
    end

endmodule
